@@ design/wufc_pkg.sv @@
// Shared types and constants for the weighted union-find checker.
package wufc_pkg;
  localparam int NodeW = 10;
  localparam int DistW = 32;
  localparam int OffW  = 48;

  typedef struct packed {
    logic [NodeW-1:0]        left_node;
    logic [NodeW-1:0]        right_node;
    logic signed [DistW-1:0] distance;
  } wufc_in_t;

  typedef struct packed {
    logic consistent;
    logic merged;
    logic all_consistent;
  } wufc_out_t;
endpackage

@@ design/weighted_union_find_checker.sv @@
// Weighted union-find checker: one item at a time, root walks through one shared adder.
// Each walk step passes S_RD, S_WAIT, S_STEP; the left walk, the right walk, S_CMP and, on
//   a merge, S_MERGE precede the result beat; depth is bounded near log2(NODES) by union by size.
// Throughput: one item at a time; in_stall stays high until the result beat is taken.
// Reset: synchronous; after reset a clearing pass over every node address initializes the
//   parent, size and offset memories, during which no input beat is accepted.
module weighted_union_find_checker #(
  parameter int NODES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wufc_pkg::wufc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wufc_pkg::wufc_out_t out_data
);
  import wufc_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW = AW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_STEP, S_NEXT, S_CMP, S_MERGE, S_OUT
  } state_t;

  // One memory row per node: parent, set size and offset to parent.
  logic [AW-1:0]   parent_mem [NODES];
  logic [SW-1:0]   size_mem   [NODES];
  logic [OffW-1:0] off_mem    [NODES];

  state_t          state;
  logic [AW-1:0]   addr;       // read address / clear pointer
  logic [AW-1:0]   cur;
  logic [AW-1:0]   rd_parent;
  logic [SW-1:0]   rd_size;
  logic [OffW-1:0] rd_off;
  logic [OffW-1:0] acc;        // potential of cur relative to walk start
  logic            side;       // 0 walks left, 1 walks right
  logic [AW-1:0]   node_b, root_a;
  logic [OffW-1:0] pot_a;
  logic [SW-1:0]   size_a;
  logic [OffW-1:0] req_dist;
  logic            sticky_ok;
  logic            mg;
  logic [OffW-1:0] sum;        // the shared adder
  logic [OffW-1:0] add_a, add_b;
  logic            wr_en;
  logic [AW-1:0]   wr_addr, wr_parent;
  logic [OffW-1:0] wr_off;
  logic            wr2_en;
  logic [AW-1:0]   wr2_addr;
  logic [SW-1:0]   wr2_size;

  function automatic logic [AW-1:0] red(input logic [NodeW-1:0] n);
    logic [NodeW+AW:0] v;
    v = (NodeW+AW+1)'(n);
    for (int k = NodeW - 1; k >= 0; k--) begin
      if (v >= ((NodeW+AW+1)'(NODES) << k)) v = v - ((NodeW+AW+1)'(NODES) << k);
    end
    return v[AW-1:0];
  endfunction

  assign sum = add_a + add_b;

  always_comb begin
    add_a = acc;
    add_b = rd_off;
    if (state == S_CMP) begin
      // Merge offset: d + pa - pb, using acc = pb; computed as (d + pa) - pb.
      add_a = req_dist + pot_a;
      add_b = -acc;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_mem[wr_addr] <= wr_parent;
      off_mem[wr_addr]    <= wr_off;
    end
    if (wr2_en) size_mem[wr2_addr] <= wr2_size;
    rd_parent <= parent_mem[addr];
    rd_size   <= size_mem[addr];
    rd_off    <= off_mem[addr];
  end

  always_ff @(posedge clk) begin
    wr_en  <= 1'b0;
    wr2_en <= 1'b0;
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      sticky_ok <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          wr_en     <= 1'b1;
          wr_addr   <= addr;
          wr_parent <= addr;
          wr_off    <= '0;
          wr2_en    <= 1'b1;
          wr2_addr  <= addr;
          wr2_size  <= SW'(1);
          if (addr == AW'(NODES-1)) begin
            state <= S_IDLE;
          end
          addr <= addr + AW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            node_b   <= red(in_data.right_node);
            req_dist <= OffW'(in_data.distance);
            cur      <= red(in_data.left_node);
            addr     <= red(in_data.left_node);
            acc      <= '0;
            side     <= 1'b0;
            state    <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_STEP;
        S_STEP: begin
          if (rd_parent == cur) begin
            state <= S_NEXT;
          end else begin
            acc   <= sum;
            cur   <= rd_parent;
            addr  <= rd_parent;
            state <= S_RD;
          end
        end
        S_NEXT: begin
          if (!side) begin
            root_a <= cur;
            pot_a  <= acc;
            size_a <= rd_size;
            side   <= 1'b1;
            acc    <= '0;
            cur    <= node_b;
            addr   <= node_b;
            state  <= S_RD;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (cur == root_a) begin
            mg <= 1'b0;
            if ((acc - pot_a) != req_dist) sticky_ok <= 1'b0;
            out_data.consistent <= ((acc - pot_a) == req_dist);
            out_data.merged     <= 1'b0;
            out_data.all_consistent <= sticky_ok && ((acc - pot_a) == req_dist);
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            mg <= 1'b1;
            wr_en  <= 1'b1;
            wr2_en <= 1'b1;
            if (size_a < rd_size) begin
              wr_addr   <= root_a;
              wr_parent <= cur;
              wr_off    <= -sum;
              wr2_addr  <= cur;
            end else begin
              wr_addr   <= cur;
              wr_parent <= root_a;
              wr_off    <= sum;
              wr2_addr  <= root_a;
            end
            wr2_size <= size_a + rd_size;
            state    <= S_MERGE;
          end
        end
        S_MERGE: begin
          out_data.consistent     <= 1'b1;
          out_data.merged         <= mg;
          out_data.all_consistent <= sticky_ok;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/wufc_checker.sv @@
// Port-level assertions for the weighted union-find checker, bound into every instance of it.
module wufc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wufc_pkg::wufc_out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.merged |-> out_data.consistent)
    else $error("merge reported inconsistent");
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.consistent |-> !out_data.all_consistent)
    else $error("sticky flag missed a failure");
endmodule

bind weighted_union_find_checker wufc_checker u_wufc_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for the weighted union-find checker: directed and random constraints.
`timescale 1ns / 100ps

module tb_top;
  import wufc_pkg::*;

  localparam int NodeCount = 1024;
  localparam int RandomBeats = 1750;
  localparam int CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  wufc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wufc_out_t out_data;

  always #5 clk = ~clk;

  weighted_union_find_checker #(.NODES(NodeCount)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow union-find store. Potentials are kept in 64 bits; only the low 48
  // bits of each offset are ever meaningful, exactly as in the block.
  int unsigned shadow_parent [NodeCount];
  int unsigned shadow_size [NodeCount];
  logic signed [63:0] shadow_offset [NodeCount];
  logic shadow_sticky;

  wufc_in_t pending_beats [$];
  wufc_out_t expected_verdicts [$];
  int error_count = 0;
  int cycle_count = 0;

  // Control knobs shared between the stimulus process and the clocked blocks.
  bit idle_enable = 1'b1;
  bit send_hold = 1'b0;
  int recv_hold_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stimulus_done = 1'b0;

  function automatic logic signed [63:0] sext48(logic [63:0] v);
    return {{16{v[47]}}, v[47:0]};
  endfunction

  // Walks the parent chain of a node and returns its root and potential.
  task automatic walk_to_root(input int unsigned node, output int unsigned root,
                              output logic signed [63:0] pot);
    int unsigned cur;
    cur = node;
    pot = '0;
    while (shadow_parent[cur] != cur) begin
      pot += sext48(shadow_offset[cur]);
      cur = shadow_parent[cur];
    end
    root = cur;
  endtask

  // Applies one constraint to the shadow store and queues the verdict it gives.
  task automatic apply_constraint(input wufc_in_t beat);
    int unsigned ra, rb, tmp;
    logic signed [63:0] pa, pb, d, x;
    wufc_out_t verdict;
    walk_to_root(beat.left_node, ra, pa);
    walk_to_root(beat.right_node, rb, pb);
    d = {{32{beat.distance[31]}}, beat.distance};
    verdict = '0;
    if (ra == rb) begin
      verdict.consistent = ((pb - pa) == d);
    end else begin
      x = d + pa - pb;
      // Ties keep the left root on top.
      if (shadow_size[ra] < shadow_size[rb]) begin
        tmp = ra;
        ra = rb;
        rb = tmp;
        x = -x;
      end
      shadow_parent[rb] = ra;
      shadow_size[ra] += shadow_size[rb];
      shadow_offset[rb] = sext48(x);
      verdict.consistent = 1'b1;
      verdict.merged = 1'b1;
    end
    if (!verdict.consistent) shadow_sticky = 1'b0;
    verdict.all_consistent = shadow_sticky;
    expected_verdicts.push_back(verdict);
  endtask

  task automatic report_mismatch(input string what);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic queue_beat(input int unsigned l, input int unsigned r, input int delta);
    wufc_in_t beat;
    beat.left_node = l[9:0];
    beat.right_node = r[9:0];
    beat.distance = delta;
    pending_beats.push_back(beat);
  endtask

  // Driver: presents the head of the pending queue. Gaps only start while
  // nothing is on offer, so valid never drops under a stalled beat. The
  // prediction is made at the accepting edge, so the shadow store follows the
  // block's order of acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        apply_constraint(in_data);
        void'(pending_beats.pop_front());
      end
      if (in_valid && in_stall) begin
        // Hold the stalled beat unchanged.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else begin
        if (pending_beats.size() > 0 && !send_hold) begin
          in_data <= pending_beats[0];
          in_valid <= 1'b1;
          if (idle_enable && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result beat and drives the receiver's stall, with
  // random bursts and an occasional long hold-off counted here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          wufc_out_t want;
          want = expected_verdicts.pop_front();
          if (out_data.consistent !== want.consistent)
            report_mismatch($sformatf("consistent %b want %b", out_data.consistent,
                                      want.consistent));
          if (out_data.merged !== want.merged)
            report_mismatch($sformatf("merged %b want %b", out_data.merged, want.merged));
          if (out_data.all_consistent !== want.all_consistent)
            report_mismatch($sformatf("all_consistent %b want %b",
                                      out_data.all_consistent, want.all_consistent));
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Queues constraints between random pairs of a small node group with a
  // hidden potential per node, each distance agreeing with those potentials;
  // now and then a wrong distance is slipped in.
  task automatic queue_random_group(input int beats);
    int unsigned nodes [8];
    int pot [8];
    int i, j, k, spread;
    spread = $urandom_range(0, 3);
    for (i = 0; i < 8; i++) begin
      nodes[i] = $urandom_range(0, NodeCount - 1);
      pot[i] = (spread == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
    end
    for (k = 0; k < beats; k++) begin
      i = $urandom_range(0, 7);
      j = $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0)
        queue_beat(nodes[i], nodes[j], $urandom);
      else
        queue_beat(nodes[i], nodes[j], pot[j] - pot[i]);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_beats.size() != 0 || expected_verdicts.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    int queued;
    for (int n = 0; n < NodeCount; n++) begin
      shadow_parent[n] = n;
      shadow_size[n] = 1;
      shadow_offset[n] = '0;
    end
    shadow_sticky = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: same node with zero and non-zero distance, extreme node
    // indexes and distances, a tie merge, a check through a merge, and the
    // first inconsistent item that clears the sticky flag.
    queue_beat(0, 0, 0);
    queue_beat(1023, 0, 32'h7fffffff);
    queue_beat(5, 6, 32'h80000000);
    queue_beat(1023, 0, 32'h7fffffff);
    queue_beat(0, 1023, 32'h80000001);
    queue_beat(6, 5, 32'h7fffffff);
    queue_beat(5, 1023, 7);
    queue_beat(0, 6, 32'h7fffffff);
    queue_beat(682, 341, -1);
    queue_beat(341, 682, 1);
    queue_beat(512, 511, 32'hffffffff);
    queue_beat(682, 512, 3);
    queue_beat(511, 341, 100);
    queue_beat(7, 7, 1);
    queue_beat(0, 1023, 0);
    queue_beat(7, 7, 0);
    queue_beat(5, 6, 32'h80000000);

    // The block is full while the receiver holds off for a long stretch.
    recv_hold_cycles = 300;
    wait_for_drain();

    // Random part: mostly consistent constraints within small node groups.
    queued = 0;
    while (queued < RandomBeats) begin
      int n;
      n = $urandom_range(4, 30);
      if ($urandom_range(0, 9) == 0) begin
        queue_beat($urandom_range(0, NodeCount - 1), $urandom_range(0, NodeCount - 1),
                   $urandom);
        n = 1;
      end else begin
        queue_random_group(n);
      end
      queued += n;
      if (queued > RandomBeats / 2 && queued - n <= RandomBeats / 2) begin
        // The sender pauses until every expected result has come.
        wait_for_drain();
      end
      if (queued > RandomBeats * 4 / 5) idle_enable = 1'b0;
      while (pending_beats.size() > 40) @(posedge clk);
    end

    wait_for_drain();
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
